### rtl/core/qsu_pkg.sv
// ----------------------------------------------------------------------------
// qsu_pkg: shared types, codes and helpers of the quoted string unescaper
// Character codes, result kinds, parser phases, state and result structs.
// ----------------------------------------------------------------------------
package qsu_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   // result kinds
   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_DONE = 2'd1;
   localparam logic [1:0] KIND_FAIL = 2'd2;

   // parser phases
   localparam logic [2:0] PH_SEEK = 3'd0;
   localparam logic [2:0] PH_BODY = 3'd1;
   localparam logic [2:0] PH_ESC  = 3'd2;
   localparam logic [2:0] PH_HEX0 = 3'd3;
   localparam logic [2:0] PH_HEX1 = 3'd4;
   localparam logic [2:0] PH_OCT  = 3'd5;

   // characters
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_SEVEN     = 8'h37;
   localparam logic [7:0] CH_NINE      = 8'h39;
   localparam logic [7:0] CH_UP_A      = 8'h41;
   localparam logic [7:0] CH_UP_F      = 8'h46;
   localparam logic [7:0] CH_LO_A      = 8'h61;
   localparam logic [7:0] CH_LO_B      = 8'h62;
   localparam logic [7:0] CH_LO_F      = 8'h66;
   localparam logic [7:0] CH_LO_N      = 8'h6E;
   localparam logic [7:0] CH_LO_R      = 8'h72;
   localparam logic [7:0] CH_LO_T      = 8'h74;
   localparam logic [7:0] CH_LO_V      = 8'h76;
   localparam logic [7:0] CH_LO_X      = 8'h78;

   // control codes produced by the simple escapes
   localparam logic [7:0] CODE_BELL = 8'h07;
   localparam logic [7:0] CODE_BS   = 8'h08;
   localparam logic [7:0] CODE_TAB  = 8'h09;
   localparam logic [7:0] CODE_LF   = 8'h0A;
   localparam logic [7:0] CODE_VT   = 8'h0B;
   localparam logic [7:0] CODE_FF   = 8'h0C;
   localparam logic [7:0] CODE_CR   = 8'h0D;

   typedef struct packed {
      logic [2:0]             phase;
      logic [8:0]             held_value;
      logic [1:0]             octal_digits;
      logic [COUNT_WIDTH-1:0] byte_counter;
   } state_type;

   typedef struct packed {
      logic [1:0]             kind;
      logic [7:0]             decoded_byte;
      logic [COUNT_WIDTH-1:0] consumed_count;
      logic                   run_last;
   } result_type;

   typedef struct packed {
      state_type  next_state;
      logic [1:0] count;
      result_type res1;
      result_type res0;
   } step_type;

   localparam state_type STATE_IDLE = '{
      phase:        PH_SEEK,
      held_value:   9'd0,
      octal_digits: 2'd0,
      byte_counter: '0
   };

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic is_oct(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_SEVEN);
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return ((c >= CH_ZERO) && (c <= CH_NINE)) ||
             ((c >= CH_LO_A) && (c <= CH_LO_F)) ||
             ((c >= CH_UP_A) && (c <= CH_UP_F));
   endfunction

   // valid for hex digit characters only; letters have low nibble 1..6
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      if (c <= CH_NINE) begin
         return c[3:0];
      end
      return c[3:0] + 4'd9;
   endfunction

   function automatic logic [7:0] simple_escape(input logic [7:0] c);
      logic [7:0] r;
      case (c)
         CH_LO_A: r = CODE_BELL;
         CH_LO_B: r = CODE_BS;
         CH_LO_N: r = CODE_LF;
         CH_LO_R: r = CODE_CR;
         CH_LO_F: r = CODE_FF;
         CH_LO_T: r = CODE_TAB;
         CH_LO_V: r = CODE_VT;
         default: r = c;
      endcase
      return r;
   endfunction

   function automatic result_type make_result(input logic [1:0] kind,
                                              input logic [7:0] value,
                                              input logic [COUNT_WIDTH-1:0] count);
      result_type r;
      r.kind           = kind;
      r.decoded_byte   = value;
      r.consumed_count = count;
      r.run_last       = 1'b0;
      return r;
   endfunction

endpackage

### rtl/core/qsu_req_if.sv
// ----------------------------------------------------------------------------
// qsu_req_if: input channel of the quoted string unescaper
// One raw text byte per word, with a flag for the last byte of a buffer.
// ----------------------------------------------------------------------------
interface qsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       buffer_end;

   modport source (output valid, output text_byte, output buffer_end, input ready);
   modport sink   (input valid, input text_byte, input buffer_end, output ready);
endinterface

### rtl/core/qsu_rsp_if.sv
// ----------------------------------------------------------------------------
// qsu_rsp_if: result channel of the quoted string unescaper
// One decoded byte, completion or failure word per handshake.
// ----------------------------------------------------------------------------
interface qsu_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      kind;
   logic [7:0]                      decoded_byte;
   logic [qsu_pkg::COUNT_WIDTH-1:0] consumed_count;
   logic                            run_last;

   modport source (output valid, output kind, output decoded_byte,
                   output consumed_count, output run_last, input ready);
   modport sink   (input valid, input kind, input decoded_byte,
                   input consumed_count, input run_last, output ready);
endinterface

### rtl/core/qsu_decode.sv
// ----------------------------------------------------------------------------
// qsu_decode: per-byte parser step
// From the current state and one text byte, forms the next state and up to
// two result words.
// ----------------------------------------------------------------------------
module qsu_decode (
   input  qsu_pkg::state_type state,
   input  logic [7:0]         text_byte,
   input  logic               buffer_end,
   output qsu_pkg::step_type  step
);

   qsu_pkg::state_type                nx;
   qsu_pkg::result_type               res [2];
   logic [qsu_pkg::COUNT_WIDTH-1:0]   count_inc;
   logic [1:0]                        n;
   logic                              run_body;
   logic                              done;
   logic                              fail;
   logic [8:0]                        oct_acc;
   logic [1:0]                        oct_cnt;

   always_comb begin
      nx       = state;
      res[0]   = qsu_pkg::make_result(qsu_pkg::KIND_BYTE, 8'd0, '0);
      res[1]   = qsu_pkg::make_result(qsu_pkg::KIND_BYTE, 8'd0, '0);
      n        = 2'd0;
      run_body = 1'b0;
      done     = 1'b0;
      fail     = 1'b0;
      oct_acc  = {state.held_value[5:0], 3'b000} + {6'd0, text_byte[2:0]};
      oct_cnt  = state.octal_digits + 2'd1;

      count_inc = state.byte_counter;
      if (state.byte_counter != qsu_pkg::COUNT_MAX) begin
         count_inc = state.byte_counter + 1'b1;
      end
      nx.byte_counter = count_inc;

      unique case (state.phase)
         qsu_pkg::PH_SEEK: begin
            if (text_byte == qsu_pkg::CH_QUOTE) begin
               nx.phase = qsu_pkg::PH_BODY;
            end else if (!qsu_pkg::is_space(text_byte)) begin
               fail = 1'b1;
            end
         end
         qsu_pkg::PH_BODY: begin
            run_body = 1'b1;
         end
         qsu_pkg::PH_ESC: begin
            if (text_byte == qsu_pkg::CH_LO_X) begin
               nx.phase = qsu_pkg::PH_HEX0;
            end else if (qsu_pkg::is_oct(text_byte)) begin
               nx.held_value   = {6'd0, text_byte[2:0]};
               nx.octal_digits = 2'd1;
               nx.phase        = qsu_pkg::PH_OCT;
            end else begin
               res[0] = qsu_pkg::make_result(qsu_pkg::KIND_BYTE,
                                             qsu_pkg::simple_escape(text_byte), '0);
               n        = 2'd1;
               nx.phase = qsu_pkg::PH_BODY;
            end
         end
         qsu_pkg::PH_HEX0: begin
            if (qsu_pkg::is_hex(text_byte)) begin
               nx.held_value = {1'b0, text_byte};
               nx.phase      = qsu_pkg::PH_HEX1;
            end else begin
               nx.phase = qsu_pkg::PH_BODY;
               run_body = 1'b1;
            end
         end
         qsu_pkg::PH_HEX1: begin
            nx.phase = qsu_pkg::PH_BODY;
            n        = 2'd1;
            if (qsu_pkg::is_hex(text_byte)) begin
               res[0] = qsu_pkg::make_result(qsu_pkg::KIND_BYTE,
                           {qsu_pkg::hex_value(state.held_value[7:0]),
                            qsu_pkg::hex_value(text_byte)}, '0);
            end else begin
               // broken hex escape: the held digit goes out as plain text
               res[0]   = qsu_pkg::make_result(qsu_pkg::KIND_BYTE,
                                               state.held_value[7:0], '0);
               run_body = 1'b1;
            end
         end
         qsu_pkg::PH_OCT: begin
            if (qsu_pkg::is_oct(text_byte)) begin
               nx.held_value   = oct_acc;
               nx.octal_digits = oct_cnt;
               if (oct_cnt == 2'd3) begin
                  res[0]   = qsu_pkg::make_result(qsu_pkg::KIND_BYTE, oct_acc[7:0], '0);
                  n        = 2'd1;
                  nx.phase = qsu_pkg::PH_BODY;
               end
            end else begin
               res[0]   = qsu_pkg::make_result(qsu_pkg::KIND_BYTE,
                                               state.held_value[7:0], '0);
               n        = 2'd1;
               nx.phase = qsu_pkg::PH_BODY;
               run_body = 1'b1;
            end
         end
         default: begin
            fail = 1'b1;
         end
      endcase

      // plain body text, possibly after a flushed escape word
      if (run_body) begin
         if (text_byte == qsu_pkg::CH_QUOTE) begin
            res[n[0]] = qsu_pkg::make_result(qsu_pkg::KIND_DONE, 8'd0, count_inc);
            n         = n + 2'd1;
            done      = 1'b1;
         end else if (text_byte == qsu_pkg::CH_BACKSLASH) begin
            nx.phase = qsu_pkg::PH_ESC;
         end else begin
            res[n[0]] = qsu_pkg::make_result(qsu_pkg::KIND_BYTE, text_byte, '0);
            n         = n + 2'd1;
         end
      end

      if (fail || (buffer_end && !done)) begin
         res[0] = qsu_pkg::make_result(qsu_pkg::KIND_FAIL, 8'd0, '0);
         n      = 2'd1;
         done   = 1'b1;
      end

      if (done) begin
         nx = qsu_pkg::STATE_IDLE;
      end
      if (nx.phase == qsu_pkg::PH_BODY) begin
         nx.held_value   = 9'd0;
         nx.octal_digits = 2'd0;
      end

      if (n == 2'd1) begin
         res[0].run_last = 1'b1;
      end
      if (n == 2'd2) begin
         res[1].run_last = 1'b1;
      end

      step.next_state = nx;
      step.count      = n;
      step.res0       = res[0];
      step.res1       = res[1];
   end

endmodule

### rtl/core/qsu_rsp_queue.sv
// ----------------------------------------------------------------------------
// qsu_rsp_queue: result word queue
// Shift queue: takes up to two words per cycle; sends one per cycle if ready.
// ----------------------------------------------------------------------------
module qsu_rsp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_en,
   input  qsu_pkg::step_type  push_step,
   output logic               space_ok,
   qsu_rsp_if.source          rsp_chan
);

   qsu_pkg::result_type               word_ff [qsu_pkg::QUEUE_DEPTH];
   qsu_pkg::result_type               word_in [qsu_pkg::QUEUE_DEPTH];
   logic [qsu_pkg::QCNT_WIDTH-1:0]    cnt_ff;
   logic [qsu_pkg::QCNT_WIDTH-1:0]    cnt_in;
   logic [qsu_pkg::QCNT_WIDTH-1:0]    cnt_kept;
   logic [qsu_pkg::QCNT_WIDTH-1:0]    push_n;
   logic                              pop;

   assign pop      = rsp_chan.valid && rsp_chan.ready;
   assign push_n   = push_en ? {{(qsu_pkg::QCNT_WIDTH-2){1'b0}}, push_step.count} : '0;
   assign cnt_kept = cnt_ff - {{(qsu_pkg::QCNT_WIDTH-1){1'b0}}, pop};
   assign cnt_in   = cnt_kept + push_n;
   // room for a two-word item
   assign space_ok = (cnt_ff <= qsu_pkg::QCNT_WIDTH'(qsu_pkg::QUEUE_DEPTH - 2));

   always_comb begin
      for (int i = 0; i < qsu_pkg::QUEUE_DEPTH; i++) begin
         if (pop && (i < qsu_pkg::QUEUE_DEPTH - 1)) begin
            word_in[i] = word_ff[(i + 1) % qsu_pkg::QUEUE_DEPTH];
         end else begin
            word_in[i] = word_ff[i];
         end
         if ((push_n != '0) && (qsu_pkg::QCNT_WIDTH'(i) == cnt_kept)) begin
            word_in[i] = push_step.res0;
         end
         if ((push_n == qsu_pkg::QCNT_WIDTH'(2)) &&
             (qsu_pkg::QCNT_WIDTH'(i) == cnt_kept + 1'b1)) begin
            word_in[i] = push_step.res1;
         end
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign rsp_chan.valid          = (cnt_ff != '0);
   assign rsp_chan.kind           = word_ff[0].kind;
   assign rsp_chan.decoded_byte   = word_ff[0].decoded_byte;
   assign rsp_chan.consumed_count = word_ff[0].consumed_count;
   assign rsp_chan.run_last       = word_ff[0].run_last;

`ifndef SYNTH
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= qsu_pkg::QCNT_WIDTH'(qsu_pkg::QUEUE_DEPTH))
      else $error("result queue overflow");
`endif

endmodule

### rtl/core/quoted_string_unescaper_unit.sv
// ----------------------------------------------------------------------------
// quoted_string_unescaper_unit: C-style quoted string decoder
// Decodes a byte per cycle unless stalled: string bytes, completion, failure.
// ----------------------------------------------------------------------------
// req_chan carries one raw byte per word with buffer_end marking the last
// byte of a buffer. rsp_chan returns words of kind decoded byte, string
// complete (with the saturated consumed count) or failure; run_last marks the
// last word caused by one input byte. A byte yields zero, one or two words.
// The combinational parser step feeds a four-word result queue, so a byte's
// words are registered into the queue at the edge that takes the byte.
// Throughput is one byte per cycle while each byte yields at most one word
// and rsp_chan stays ready; a byte that flushes an escape yields two words,
// and req_chan.ready drops while the queue holds more than two words.
// A stalled rsp_chan fills the queue and then holds req_chan off;
// no word is dropped. Reset empties the queue and returns the parser to
// skipping whitespace before an opening quote with a zero byte count.
// After a completion or failure the parser starts a fresh session.
// ----------------------------------------------------------------------------
module quoted_string_unescaper_unit (
   input  logic       clock,
   input  logic       reset,
   qsu_req_if.sink    req_chan,
   qsu_rsp_if.source  rsp_chan
);

   qsu_pkg::state_type state_ff;
   qsu_pkg::state_type state_in;
   qsu_pkg::step_type  step;
   logic               space_ok;
   logic               accept;

   assign req_chan.ready = space_ok;
   assign accept         = req_chan.valid && space_ok;

   qsu_decode u_decode (
      .state      (state_ff),
      .text_byte  (req_chan.text_byte),
      .buffer_end (req_chan.buffer_end),
      .step       (step)
   );

   assign state_in = accept ? step.next_state : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= qsu_pkg::STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   qsu_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_en   (accept),
      .push_step (step),
      .space_ok  (space_ok),
      .rsp_chan  (rsp_chan)
   );

`ifndef SYNTH
   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.buffer_end |=>
         state_ff.phase == qsu_pkg::PH_SEEK && state_ff.byte_counter == '0)
      else $error("buffer end did not restart the session");

   a_body_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == qsu_pkg::PH_BODY |->
         state_ff.held_value == 9'd0 && state_ff.octal_digits == 2'd0)
      else $error("escape state left over in body");

   a_open_counted: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase != qsu_pkg::PH_SEEK |-> state_ff.byte_counter != '0)
      else $error("open string with zero byte count");

   a_word_count: assert property (@(posedge clock) disable iff (reset)
      accept |-> step.count != 2'd3)
      else $error("more than two words for one byte");
`endif

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for quoted_string_unescaper_unit
// Feeds directed and random text (whitespace, quoted strings with escapes,
// broken strings and noise), predicts every decoded word and compares the
// result channel against the prediction.
// ----------------------------------------------------------------------------
module testbench;

   typedef struct packed {
      logic [7:0] text;
      logic       last;
   } text_word_type;

   logic clock = 1'b0;
   logic reset;

   qsu_req_if req_if ();
   qsu_rsp_if rsp_if ();

   quoted_string_unescaper_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   text_word_type       pending_text [$];
   text_word_type       draft_text [$];
   qsu_pkg::result_type decode_queue [$];

   logic                   req_taken = 1'b0;
   int                     cycle_count = 0;
   int                     fail_count = 0;

   // decoder state as seen from outside
   logic [2:0]                      dec_phase = qsu_pkg::PH_SEEK;
   logic [8:0]                      dec_held = '0;
   logic [1:0]                      dec_digits = '0;
   logic [qsu_pkg::COUNT_WIDTH-1:0] dec_count = '0;

   // words caused by the byte being decoded
   qsu_pkg::result_type    step_out [2];
   int                     step_n;
   logic                   step_done;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void add_text(input logic [7:0] t, input logic l);
      text_word_type w;
      w.text = t;
      w.last = l;
      pending_text.insert(pending_text.size(), w);
   endfunction

   function automatic void add_draft(input logic [7:0] t, input logic l);
      text_word_type w;
      w.text = t;
      w.last = l;
      draft_text.insert(draft_text.size(), w);
   endfunction

   function automatic void add_word(input qsu_pkg::result_type r);
      decode_queue.insert(decode_queue.size(), r);
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return c == qsu_pkg::CH_SPACE || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_octal_char(input logic [7:0] c);
      return c >= qsu_pkg::CH_ZERO && c <= qsu_pkg::CH_SEVEN;
   endfunction

   function automatic logic is_hex_char(input logic [7:0] c);
      return (c >= qsu_pkg::CH_ZERO && c <= qsu_pkg::CH_NINE) ||
             (c >= qsu_pkg::CH_LO_A && c <= qsu_pkg::CH_LO_F) ||
             (c >= qsu_pkg::CH_UP_A && c <= qsu_pkg::CH_UP_F);
   endfunction

   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      if (c <= qsu_pkg::CH_NINE) begin
         return 4'(c - qsu_pkg::CH_ZERO);
      end else if (c >= qsu_pkg::CH_LO_A) begin
         return 4'(c - qsu_pkg::CH_LO_A + 8'd10);
      end
      return 4'(c - qsu_pkg::CH_UP_A + 8'd10);
   endfunction

   function automatic logic [7:0] random_hex_digit();
      int r;
      r = $urandom_range(0, 21);
      if (r < 10) begin
         return 8'(qsu_pkg::CH_ZERO + r);
      end else if (r < 16) begin
         return 8'(qsu_pkg::CH_LO_A + r - 10);
      end
      return 8'(qsu_pkg::CH_UP_A + r - 16);
   endfunction

   function automatic void emit(input logic [1:0] kind, input logic [7:0] value,
                                input logic [qsu_pkg::COUNT_WIDTH-1:0] count);
      step_out[step_n] = '{kind, value, count, 1'b0};
      step_n++;
   endfunction

   task automatic plain_char(input logic [7:0] c);
      if (c == qsu_pkg::CH_QUOTE) begin
         emit(qsu_pkg::KIND_DONE, 8'd0, dec_count);
         step_done = 1'b1;
      end else if (c == qsu_pkg::CH_BACKSLASH) begin
         dec_phase = qsu_pkg::PH_ESC;
      end else begin
         emit(qsu_pkg::KIND_BYTE, c, '0);
      end
   endtask

   // one accepted byte: advance the decoder and queue the words it causes
   task automatic decode_step(input logic [7:0] c, input logic last);
      logic       fail;
      logic [7:0] mapped;
      fail      = 1'b0;
      step_n    = 0;
      step_done = 1'b0;
      if (dec_count != qsu_pkg::COUNT_MAX) begin
         dec_count++;
      end
      case (dec_phase)
         qsu_pkg::PH_SEEK: begin
            if (c == qsu_pkg::CH_QUOTE) begin
               dec_phase = qsu_pkg::PH_BODY;
            end else if (!is_blank(c)) begin
               fail = 1'b1;
            end
         end
         qsu_pkg::PH_BODY: plain_char(c);
         qsu_pkg::PH_ESC: begin
            if (c == qsu_pkg::CH_LO_X) begin
               dec_phase = qsu_pkg::PH_HEX0;
            end else if (is_octal_char(c)) begin
               dec_held   = 9'(c - qsu_pkg::CH_ZERO);
               dec_digits = 2'd1;
               dec_phase  = qsu_pkg::PH_OCT;
            end else begin
               case (c)
                  qsu_pkg::CH_LO_A: mapped = qsu_pkg::CODE_BELL;
                  qsu_pkg::CH_LO_B: mapped = qsu_pkg::CODE_BS;
                  qsu_pkg::CH_LO_N: mapped = qsu_pkg::CODE_LF;
                  qsu_pkg::CH_LO_R: mapped = qsu_pkg::CODE_CR;
                  qsu_pkg::CH_LO_F: mapped = qsu_pkg::CODE_FF;
                  qsu_pkg::CH_LO_T: mapped = qsu_pkg::CODE_TAB;
                  qsu_pkg::CH_LO_V: mapped = qsu_pkg::CODE_VT;
                  default:          mapped = c;
               endcase
               emit(qsu_pkg::KIND_BYTE, mapped, '0);
               dec_phase = qsu_pkg::PH_BODY;
            end
         end
         qsu_pkg::PH_HEX0: begin
            if (is_hex_char(c)) begin
               dec_held  = {1'b0, c};
               dec_phase = qsu_pkg::PH_HEX1;
            end else begin
               dec_phase = qsu_pkg::PH_BODY;
               plain_char(c);
            end
         end
         qsu_pkg::PH_HEX1: begin
            dec_phase = qsu_pkg::PH_BODY;
            if (is_hex_char(c)) begin
               emit(qsu_pkg::KIND_BYTE, {hex_nibble(dec_held[7:0]), hex_nibble(c)}, '0);
            end else begin
               // broken \x with one digit: the digit comes back as text
               emit(qsu_pkg::KIND_BYTE, dec_held[7:0], '0);
               plain_char(c);
            end
         end
         qsu_pkg::PH_OCT: begin
            if (is_octal_char(c)) begin
               dec_held   = (dec_held << 3) + 9'(c - qsu_pkg::CH_ZERO);
               dec_digits = dec_digits + 2'd1;
               if (dec_digits >= 2'd3) begin
                  emit(qsu_pkg::KIND_BYTE, dec_held[7:0], '0);
                  dec_phase = qsu_pkg::PH_BODY;
               end
            end else begin
               emit(qsu_pkg::KIND_BYTE, dec_held[7:0], '0);
               dec_phase = qsu_pkg::PH_BODY;
               plain_char(c);
            end
         end
         default: fail = 1'b1;
      endcase
      if (fail || (last && !step_done)) begin
         step_n = 0;
         emit(qsu_pkg::KIND_FAIL, 8'd0, '0);
         step_done = 1'b1;
      end
      if (step_done) begin
         dec_phase  = qsu_pkg::PH_SEEK;
         dec_held   = '0;
         dec_digits = '0;
         dec_count  = '0;
      end
      if (dec_phase == qsu_pkg::PH_BODY) begin
         dec_held   = '0;
         dec_digits = '0;
      end
      if (step_n > 0) begin
         step_out[step_n-1].run_last = 1'b1;
      end
      for (int i = 0; i < step_n; i++) begin
         add_word(step_out[i]);
      end
   endtask

   task automatic push_text(input string s, input logic end_last);
      for (int i = 0; i < s.len(); i++) begin
         add_text(8'(s[i]), end_last && (i == s.len() - 1));
      end
   endtask

   // both sides run without gaps inside this window
   function automatic logic no_idle();
      return cycle_count >= 1000 && cycle_count < 1800;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      req_taken   <= !reset && req_if.valid && req_if.ready;
      if (!reset && req_if.valid && req_if.ready) begin
         decode_step(req_if.text_byte, req_if.buffer_end);
      end
   end

   // driver: a word stays on the bus until taken
   always @(negedge clock) begin : drive_text
      text_word_type w;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (req_taken || !req_if.valid) begin
         if (pending_text.size() != 0 && (no_idle() || $urandom_range(0, 99) >= 33)) begin
            w = pending_text.pop_front();
            req_if.valid      <= 1'b1;
            req_if.text_byte  <= w.text;
            req_if.buffer_end <= w.last;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
      rsp_if.ready <= no_idle() || $urandom_range(0, 99) >= 33;
   end

   always @(posedge clock) begin : check_words
      qsu_pkg::result_type got;
      qsu_pkg::result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = '{rsp_if.kind, rsp_if.decoded_byte, rsp_if.consumed_count, rsp_if.run_last};
         if (decode_queue.size() == 0) begin
            if (fail_count < 10) begin
               $display("unexpected word: kind %0d byte %02h count %0d last %0b",
                        got.kind, got.decoded_byte, got.consumed_count, got.run_last);
            end
            fail_count++;
         end else begin
            want = decode_queue.pop_front();
            if (got.kind !== want.kind || got.decoded_byte !== want.decoded_byte ||
                got.consumed_count !== want.consumed_count ||
                got.run_last !== want.run_last) begin
               if (fail_count < 10) begin
                  $display("mismatch: expected kind %0d byte %02h count %0d last %0b",
                           want.kind, want.decoded_byte, want.consumed_count,
                           want.run_last);
                  $display("          got      kind %0d byte %02h count %0d last %0b",
                           got.kind, got.decoded_byte, got.consumed_count, got.run_last);
               end
               fail_count++;
            end
         end
      end
   end

   initial begin : stimulus
      string      esc_letters;
      int         total;
      int         mode;
      int         pick;
      int         k;
      int         cut;
      logic [7:0] b;
      esc_letters        = "abnrftv\\'\"";
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.text_byte   = 8'd0;
      req_if.buffer_end  = 1'b0;
      rsp_if.ready       = 1'b0;

      // bad opening, whitespace, byte extremes, simple and hex escapes
      push_text("A", 1'b0);
      push_text(" \t\"", 1'b0);
      add_text(8'h00, 1'b0);
      add_text(8'hFF, 1'b0);
      push_text("\\n\\x4f\\xG", 1'b0);
      // one hex digit then the closing quote: two words
      push_text("\\xA\"", 1'b0);
      // three digit octal overflows 8 bits; buffer ends inside the string
      push_text(" \"\\777\\12z", 1'b1);
      // buffer ends while still skipping whitespace
      push_text(" ", 1'b1);

      total = 0;
      while (total < 1600) begin
         draft_text.delete();
         mode = $urandom_range(0, 99);
         if (mode < 15) begin
            repeat ($urandom_range(1, 6)) begin
               add_draft(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end
         end else begin
            repeat ($urandom_range(0, 3)) begin
               k = $urandom_range(0, 5);
               add_draft((k == 5) ? qsu_pkg::CH_SPACE : 8'(k + 9), 1'b0);
            end
            add_draft(qsu_pkg::CH_QUOTE, 1'b0);
            repeat ($urandom_range(0, 12)) begin
               pick = $urandom_range(0, 99);
               if (pick < 40) begin
                  do begin
                     b = 8'($urandom_range(0, 255));
                  end while (b == qsu_pkg::CH_QUOTE || b == qsu_pkg::CH_BACKSLASH);
                  add_draft(b, 1'b0);
               end else if (pick < 55) begin
                  k = $urandom_range(0, 10);
                  b = (k == 10) ? 8'($urandom_range(0, 255)) : 8'(esc_letters[k]);
                  add_draft(qsu_pkg::CH_BACKSLASH, 1'b0);
                  add_draft(b, 1'b0);
               end else if (pick < 70) begin
                  add_draft(qsu_pkg::CH_BACKSLASH, 1'b0);
                  add_draft(qsu_pkg::CH_LO_X, 1'b0);
                  add_draft(random_hex_digit(), 1'b0);
                  add_draft(random_hex_digit(), 1'b0);
               end else if (pick < 78) begin
                  add_draft(qsu_pkg::CH_BACKSLASH, 1'b0);
                  add_draft(qsu_pkg::CH_LO_X, 1'b0);
                  if ($urandom_range(0, 1) == 1) begin
                     add_draft(random_hex_digit(), 1'b0);
                  end
                  add_draft(8'($urandom_range(0, 255)), 1'b0);
               end else if (pick < 93) begin
                  add_draft(qsu_pkg::CH_BACKSLASH, 1'b0);
                  repeat ($urandom_range(1, 3)) begin
                     add_draft(8'(qsu_pkg::CH_ZERO + $urandom_range(0, 7)), 1'b0);
                  end
               end else begin
                  add_draft(8'($urandom_range(0, 255)), 1'b0);
               end
            end
            add_draft(qsu_pkg::CH_QUOTE, $urandom_range(0, 4) == 0);
            // truncated string: buffer ends before its closing quote
            if (mode < 30) begin
               cut = $urandom_range(1, draft_text.size() - 1);
               while (draft_text.size() > cut) begin
                  void'(draft_text.pop_back());
               end
               draft_text[draft_text.size()-1].last = 1'b1;
            end
         end
         total += draft_text.size();
         foreach (draft_text[i]) begin
            add_text(draft_text[i].text, draft_text[i].last);
         end
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_text.size() != 0 || req_if.valid) begin
         @(posedge clock);
      end
      while (decode_queue.size() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
      fail_count += decode_queue.size();
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
